// ----- design/conv3_pkg.sv -----
// conv3_pkg: shared types and constants of the 3x3 convolution block
// no dependencies; used by conv2d_3x3_valid
package conv3_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 25;
  localparam int ROW_SUM_W  = 27;
  localparam int CONV_W     = 28;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic signed [COEF_W-1:0]     coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ROW_SUM_W-1:0]  row_sum_t;
  typedef logic signed [CONV_W-1:0]     conv_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [SIZE_W-1:0]            size_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
    logic last;
  } pos_t;

endpackage

// ----- design/conv3_ram.sv -----
// conv3_ram: generic single-write, single-read synchronous ram
// registered read data; no package dependency
module conv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/conv2d_3x3_valid.sv -----
// conv2d_3x3_valid: 3x3 valid-position correlation over a raster pixel stream
// depends on conv3_pkg and conv3_ram
//
// Takes one pixel per clock and gives at most one result per clock while the
// output is not stalled. A result passes the registered line store read, nine
// products, row sums and final sum before it leaves the output register. Both
// line stores sit side by side in one ram of LINE_MAX words; each pixel reads
// its column when accepted and writes it back as it leaves the read stage, so
// the ram's single read and write port set the rate of one pixel per cycle. After
// reset the ram is cleared to zero, one word a cycle, so no pixel is taken until
// all LINE_MAX words are cleared; configuration writes are taken at any time.
module conv2d_3x3_valid #(
  parameter int LINE_MAX = 1024,
  parameter int ROW_MAX  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  conv3_pkg::pix_t      pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output conv3_pkg::conv_t     conv_value,
  output conv3_pkg::idx_t      out_row,
  output conv3_pkg::idx_t      out_col,
  output logic                 frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  conv3_pkg::cfg_idx_t  cfg_index,
  input  conv3_pkg::cfg_data_t cfg_data
);

  import conv3_pkg::*;

  localparam int CW  = $clog2(LINE_MAX);
  localparam int RW  = $clog2(ROW_MAX);
  localparam int WW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int HW  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
  localparam int RAM_W = 2 * PIX_W;

  // configuration
  cfg_data_t coef_rows [3];
  size_t     frame_width;
  size_t     frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows[0] <= '0;
      coef_rows[1] <= '0;
      coef_rows[2] <= '0;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_ROW0:    coef_rows[0] <= cfg_data;
        REG_COEF_ROW1:    coef_rows[1] <= cfg_data;
        REG_COEF_ROW2:    coef_rows[2] <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0] w_ext, w_eff;
  logic [HW-1:0] h_ext, h_eff;

  always_comb begin
    w_ext = WW'(frame_width);
    h_ext = HW'(frame_height);
    if (w_ext < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_ext > WW'(LINE_MAX)) begin
      w_eff = WW'(LINE_MAX);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HW'(3)) begin
      h_eff = HW'(3);
    end else if (h_ext > HW'(ROW_MAX)) begin
      h_eff = HW'(ROW_MAX);
    end else begin
      h_eff = h_ext;
    end
  end

  // clearing pass over the line stores
  logic          clearing;
  logic [CW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CW'(LINE_MAX - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + CW'(1);
      end
    end
  end

  // position counters
  logic [CW-1:0]         col_count, col_count_next;
  logic [RW-1:0]         row_count, row_count_next;
  logic                  wrap_pre, wrap_post;
  logic [CW-1:0]         c_cur;
  logic [RW:0]           r_inc;
  logic [RW-1:0]         r_cur;
  logic [WW-1:0]         c_inc;
  logic [HW-1:0]         r_post;
  logic [RW+IDX_W-1:0]   r_off;
  logic [CW+IDX_W-1:0]   c_off;
  logic                  emit_cur;
  pos_t                  pos_cur;

  always_comb begin
    wrap_pre = WW'(col_count) >= w_eff;
    c_cur    = wrap_pre ? '0 : col_count;
    r_inc    = wrap_pre ? {1'b0, row_count} + (RW+1)'(1) : {1'b0, row_count};
    r_cur    = (HW'(r_inc) >= h_eff) ? '0 : r_inc[RW-1:0];

    c_inc     = WW'(c_cur) + WW'(1);
    r_post    = HW'(r_cur) + HW'(1);
    wrap_post = c_inc >= w_eff;
    if (wrap_post) begin
      col_count_next = '0;
      row_count_next = (r_post >= h_eff) ? '0 : r_post[RW-1:0];
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = r_cur;
    end

    emit_cur = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    r_off    = (RW+IDX_W)'(r_cur) - (RW+IDX_W)'(2);
    c_off    = (CW+IDX_W)'(c_cur) - (CW+IDX_W)'(2);
    pos_cur.row  = r_off[IDX_W-1:0];
    pos_cur.col  = c_off[IDX_W-1:0];
    pos_cur.last = (HW'(r_cur) == h_eff - HW'(1)) && (WW'(c_cur) == w_eff - WW'(1));
  end

  // pipeline handshake
  logic in_acc;
  logic a_valid, a_adv, a_emit;
  logic b_valid, b_free;
  logic c_valid, c_free;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign c_free   = !c_valid || out_free;
  assign b_free   = !b_valid || c_free;
  assign a_adv    = a_valid && (!a_emit || b_free);
  assign in_ready = !clearing && (!a_valid || a_adv);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line stores: upper byte is the row two back, lower byte the previous row
  logic             ram_we, ram_re;
  logic [CW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  pix_t             a_pixel;
  logic [CW-1:0]    a_col;
  pos_t             a_pos;
  pix_t             top, mid;

  assign top       = ram_rdata[RAM_W-1:PIX_W];
  assign mid       = ram_rdata[PIX_W-1:0];
  assign ram_re    = in_acc;
  assign ram_raddr = c_cur;
  assign ram_we    = clearing || a_adv;
  assign ram_waddr = clearing ? clr_addr : a_col;
  assign ram_wdata = clearing ? '0 : {mid, a_pixel};

  conv3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_pixel <= pixel;
      a_col   <= c_cur;
      a_emit  <= emit_cur;
      a_pos   <= pos_cur;
    end
  end

  // window and products
  pix_t  win [3][3];
  pix_t  win_nx [3][3];
  coef_t coef_m [3][3];
  prod_t prod_nx [9];
  prod_t b_prod [9];
  pos_t  b_pos;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nx[i][0] = win[i][1];
      win_nx[i][1] = win[i][2];
      for (int j = 0; j < 3; j++) begin
        coef_m[i][j] = coef_rows[i][COEF_W*j +: COEF_W];
      end
    end
    win_nx[0][2] = top;
    win_nx[1][2] = mid;
    win_nx[2][2] = a_pixel;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nx[3*i+j] = $signed({1'b0, win_nx[i][j]}) * coef_m[i][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (a_adv) begin
      win <= win_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv && a_emit) begin
      b_valid <= 1'b1;
    end else if (c_free) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_emit) begin
      b_prod <= prod_nx;
      b_pos  <= a_pos;
    end
  end

  // row sums
  row_sum_t c_row [3];
  pos_t     c_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_valid) begin
      for (int i = 0; i < 3; i++) begin
        c_row[i] <= ROW_SUM_W'(b_prod[3*i]) + ROW_SUM_W'(b_prod[3*i+1])
                  + ROW_SUM_W'(b_prod[3*i+2]);
      end
      c_pos <= b_pos;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && c_valid) begin
      conv_value <= CONV_W'(c_row[0]) + CONV_W'(c_row[1]) + CONV_W'(c_row[2]);
      out_row    <= c_pos.row;
      out_col    <= c_pos.col;
      frame_last <= c_pos.last;
    end
  end

  // a read and a write-back in the same cycle never hit the same column
  assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line store read and write hit the same column");

  // no pixel enters while the line stores are being cleared
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !ram_re && !a_valid)
    else $error("pixel taken during line store clear");

  // clearing pass runs once after reset
  assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("line store clear restarted");

  // a stalled product stage holds its position
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_free) |=> (b_valid && $stable(b_pos)))
    else $error("product stage lost its word under stall");

  // a result appears only from a filled row-sum stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(c_valid))
    else $error("result without row sums");

endmodule
